// ===== rtl/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and codes of the block buffer cache directory: command and
// status codes, the per-slot directory record and the sequencer states.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_FLAGS   = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NOFREE = 2'd1;
    localparam logic [1:0] STATUS_UNREF  = 2'd2;
    localparam logic [1:0] STATUS_FULL   = 2'd3;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [7:0]  ref_count;
        logic        valid;
        logic        dirty;
    } rec_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HIT_SCAN,
        S_VIC_SCAN,
        S_SLOT_RD,
        S_SLOT_EVAL,
        S_FIND_SCAN,
        S_SHIFT,
        S_SHIFT_LAST,
        S_DONE
    } state_t;

endpackage

// ===== rtl/lru_block_buffer_cache.sv =====
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// Directory of a block buffer cache with reference counts and least recently
// used recycling. A small sequencer walks the recency order memory and the
// slot record memory one position per cycle through a two-stage read pipe.
// Sequence: get runs a hit scan from most recent, then a victim scan from
//   oldest; set flags and release update the slot record, and a release
//   that frees the slot moves it to the most recent end.
// Throughput: one request at a time; the result register lets the next
//   request be accepted while a result waits.
// Reset: synchronous active-low aresetn clears control and the per-entry
//   init bits, so all tags read as zero and order as identity at once.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache #(
    parameter int ENTRIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_device,
    input  logic [31:0] s_block_number,
    input  logic [4:0]  s_slot_in,
    input  logic        s_valid_in,
    input  logic        s_dirty_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_slot,
    output logic        m_hit,
    output logic        m_need_read,
    output logic [7:0]  m_ref_count,
    output logic [1:0]  m_status
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    // storage
    lbc_pkg::rec_t    slot_mem [ENTRIES];
    logic [IDX_W-1:0] ord_mem  [ENTRIES];
    logic [ENTRIES-1:0] slot_init_reg;
    logic [ENTRIES-1:0] ord_init_reg;

    lbc_pkg::state_t state_reg, state_next;

    // request
    logic [1:0]       cmd_reg;
    logic [7:0]       dev_reg;
    logic [31:0]      blk_reg;
    logic [4:0]       sin_reg;
    logic             vin_reg;
    logic             din_reg;
    logic [IDX_W-1:0] tgt_reg;

    // scan issue and read pipe
    logic [IDX_W-1:0] iss_pos_reg;
    logic             iss_act_reg;
    logic             iss_down_reg;
    logic             a_vld_reg;
    logic [IDX_W-1:0] a_pos_reg;
    logic [IDX_W-1:0] ord_rd_reg;
    logic             ord_rd_init_reg;
    logic             b_vld_reg;
    logic [IDX_W-1:0] b_pos_reg;
    logic [IDX_W-1:0] b_slot_reg;
    lbc_pkg::rec_t    rec_rd_reg;
    logic             rec_rd_init_reg;

    // result
    logic [4:0] res_slot_reg;
    logic       res_hit_reg;
    logic       res_nr_reg;
    logic [7:0] res_cnt_reg;
    logic [1:0] res_st_reg;

    logic             m_valid_reg;

    // derived
    logic [IDX_W-1:0] a_slot;
    lbc_pkg::rec_t    b_rec;
    logic             tag_eq;
    logic             vic_ok;
    logic             find_eq;
    logic             slot_oob;
    logic             in_acc;
    logic             out_free;

    // controls
    logic             scan_start;
    logic [IDX_W-1:0] scan_start_pos;
    logic             scan_down;
    logic [IDX_W-1:0] slot_raddr;
    logic             slot_we;
    logic [IDX_W-1:0] slot_waddr;
    lbc_pkg::rec_t    slot_wdata;
    logic             ord_we;
    logic [IDX_W-1:0] ord_waddr;
    logic [IDX_W-1:0] ord_wdata;
    logic             res_load;
    logic [4:0]       res_slot_next;
    logic             res_hit_next;
    logic             res_nr_next;
    logic [7:0]       res_cnt_next;
    logic [1:0]       res_st_next;
    logic             out_load;

    assign a_slot   = ord_rd_init_reg ? ord_rd_reg : a_pos_reg;
    assign b_rec    = rec_rd_init_reg ? rec_rd_reg : '0;
    assign tag_eq   = b_vld_reg && (b_rec.device == dev_reg)
                      && (b_rec.block_number == blk_reg);
    assign vic_ok   = b_vld_reg && (b_rec.ref_count == 8'd0) && !b_rec.dirty;
    assign find_eq  = a_vld_reg && (a_slot == tgt_reg);
    assign slot_oob = (32'(sin_reg) >= ENTRIES);
    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lbc_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (s_cmd == lbc_pkg::CMD_GET) begin
                        state_next = lbc_pkg::S_HIT_SCAN;
                    end else begin
                        state_next = lbc_pkg::S_SLOT_RD;
                    end
                end
            end
            lbc_pkg::S_HIT_SCAN: begin
                if (tag_eq) begin
                    state_next = lbc_pkg::S_DONE;
                end else if (b_vld_reg && b_pos_reg == '0) begin
                    state_next = lbc_pkg::S_VIC_SCAN;
                end
            end
            lbc_pkg::S_VIC_SCAN: begin
                if (vic_ok || (b_vld_reg && b_pos_reg == LAST)) begin
                    state_next = lbc_pkg::S_DONE;
                end
            end
            lbc_pkg::S_SLOT_RD: begin
                state_next = lbc_pkg::S_SLOT_EVAL;
            end
            lbc_pkg::S_SLOT_EVAL: begin
                if (cmd_reg == lbc_pkg::CMD_RELEASE && !slot_oob
                        && b_rec.ref_count == 8'd1) begin
                    state_next = lbc_pkg::S_FIND_SCAN;
                end else begin
                    state_next = lbc_pkg::S_DONE;
                end
            end
            lbc_pkg::S_FIND_SCAN: begin
                if (find_eq) begin
                    if (a_pos_reg == LAST) begin
                        state_next = lbc_pkg::S_SHIFT_LAST;
                    end else begin
                        state_next = lbc_pkg::S_SHIFT;
                    end
                end else if (a_vld_reg && a_pos_reg == LAST) begin
                    state_next = lbc_pkg::S_DONE;
                end
            end
            lbc_pkg::S_SHIFT: begin
                if (a_vld_reg && a_pos_reg == LAST) begin
                    state_next = lbc_pkg::S_SHIFT_LAST;
                end
            end
            lbc_pkg::S_SHIFT_LAST: begin
                state_next = lbc_pkg::S_DONE;
            end
            lbc_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = lbc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = lbc_pkg::S_IDLE;
            end
        endcase
    end

    // controls
    always_comb begin
        s_ready        = 1'b0;
        scan_start     = 1'b0;
        scan_start_pos = '0;
        scan_down      = 1'b0;
        slot_raddr     = a_slot;
        slot_we        = 1'b0;
        slot_waddr     = b_slot_reg;
        slot_wdata     = b_rec;
        ord_we         = 1'b0;
        ord_waddr      = a_pos_reg - IDX_W'(1);
        ord_wdata      = a_slot;
        res_load       = 1'b0;
        res_slot_next  = '0;
        res_hit_next   = 1'b0;
        res_nr_next    = 1'b0;
        res_cnt_next   = '0;
        res_st_next    = lbc_pkg::STATUS_OK;
        out_load       = 1'b0;
        case (state_reg)
            lbc_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (in_acc && s_cmd == lbc_pkg::CMD_GET) begin
                    scan_start     = 1'b1;
                    scan_start_pos = LAST;
                    scan_down      = 1'b1;
                end
            end
            lbc_pkg::S_HIT_SCAN: begin
                if (tag_eq) begin
                    res_load      = 1'b1;
                    res_slot_next = 5'(b_slot_reg);
                    res_hit_next  = 1'b1;
                    res_nr_next   = !b_rec.valid;
                    if (b_rec.ref_count >= lbc_pkg::COUNT_MAX) begin
                        res_cnt_next = b_rec.ref_count;
                        res_st_next  = lbc_pkg::STATUS_FULL;
                    end else begin
                        slot_we              = 1'b1;
                        slot_wdata.ref_count = b_rec.ref_count + 8'd1;
                        res_cnt_next         = b_rec.ref_count + 8'd1;
                    end
                end else if (b_vld_reg && b_pos_reg == '0) begin
                    scan_start     = 1'b1;
                    scan_start_pos = '0;
                end
            end
            lbc_pkg::S_VIC_SCAN: begin
                if (vic_ok) begin
                    slot_we                 = 1'b1;
                    slot_wdata.device       = dev_reg;
                    slot_wdata.block_number = blk_reg;
                    slot_wdata.ref_count    = 8'd1;
                    slot_wdata.valid        = 1'b0;
                    slot_wdata.dirty        = 1'b0;
                    res_load                = 1'b1;
                    res_slot_next           = 5'(b_slot_reg);
                    res_nr_next             = 1'b1;
                    res_cnt_next            = 8'd1;
                end else if (b_vld_reg && b_pos_reg == LAST) begin
                    res_load    = 1'b1;
                    res_st_next = lbc_pkg::STATUS_NOFREE;
                end
            end
            lbc_pkg::S_SLOT_RD: begin
                slot_raddr = tgt_reg;
            end
            lbc_pkg::S_SLOT_EVAL: begin
                res_load   = 1'b1;
                slot_waddr = tgt_reg;
                case (cmd_reg)
                    lbc_pkg::CMD_RELEASE: begin
                        res_slot_next = sin_reg;
                        if (slot_oob || b_rec.ref_count == 8'd0) begin
                            res_st_next = lbc_pkg::STATUS_UNREF;
                        end else begin
                            slot_we              = 1'b1;
                            slot_wdata.ref_count = b_rec.ref_count - 8'd1;
                            res_cnt_next         = b_rec.ref_count - 8'd1;
                            if (b_rec.ref_count == 8'd1) begin
                                scan_start     = 1'b1;
                                scan_start_pos = '0;
                            end
                        end
                    end
                    lbc_pkg::CMD_FLAGS: begin
                        res_slot_next = sin_reg;
                        if (!slot_oob) begin
                            slot_we          = 1'b1;
                            slot_wdata.valid = vin_reg;
                            slot_wdata.dirty = din_reg;
                            res_cnt_next     = b_rec.ref_count;
                        end
                    end
                    default: begin
                        res_slot_next = '0;
                    end
                endcase
            end
            lbc_pkg::S_FIND_SCAN: begin
                if (find_eq && a_pos_reg != LAST) begin
                    scan_start     = 1'b1;
                    scan_start_pos = a_pos_reg + IDX_W'(1);
                end
            end
            lbc_pkg::S_SHIFT: begin
                ord_we = a_vld_reg;
            end
            lbc_pkg::S_SHIFT_LAST: begin
                ord_we    = 1'b1;
                ord_waddr = LAST;
                ord_wdata = tgt_reg;
            end
            lbc_pkg::S_DONE: begin
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lbc_pkg::S_IDLE;
            iss_act_reg   <= 1'b0;
            iss_down_reg  <= 1'b0;
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            slot_init_reg <= '0;
            ord_init_reg  <= '0;
        end else begin
            state_reg <= state_next;
            a_vld_reg <= iss_act_reg && !scan_start;
            b_vld_reg <= a_vld_reg && !scan_start;
            if (scan_start) begin
                iss_act_reg  <= 1'b1;
                iss_down_reg <= scan_down;
            end else if (iss_act_reg) begin
                if (iss_pos_reg == (iss_down_reg ? '0 : LAST)) begin
                    iss_act_reg <= 1'b0;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (slot_we) begin
                slot_init_reg[slot_waddr] <= 1'b1;
            end
            if (ord_we) begin
                ord_init_reg[ord_waddr] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            cmd_reg <= s_cmd;
            dev_reg <= s_device;
            blk_reg <= s_block_number;
            sin_reg <= s_slot_in;
            vin_reg <= s_valid_in;
            din_reg <= s_dirty_in;
            tgt_reg <= IDX_W'(s_slot_in);
        end
        if (scan_start) begin
            iss_pos_reg <= scan_start_pos;
        end else if (iss_act_reg) begin
            iss_pos_reg <= iss_down_reg ? iss_pos_reg - IDX_W'(1)
                                        : iss_pos_reg + IDX_W'(1);
        end
        a_pos_reg       <= iss_pos_reg;
        ord_rd_init_reg <= ord_init_reg[iss_pos_reg];
        b_pos_reg       <= a_pos_reg;
        b_slot_reg      <= slot_raddr;
        rec_rd_init_reg <= slot_init_reg[slot_raddr];
        if (res_load) begin
            res_slot_reg <= res_slot_next;
            res_hit_reg  <= res_hit_next;
            res_nr_reg   <= res_nr_next;
            res_cnt_reg  <= res_cnt_next;
            res_st_reg   <= res_st_next;
        end
        if (out_load) begin
            m_slot      <= res_slot_reg;
            m_hit       <= res_hit_reg;
            m_need_read <= res_nr_reg;
            m_ref_count <= res_cnt_reg;
            m_status    <= res_st_reg;
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        ord_rd_reg <= ord_mem[iss_pos_reg];
        if (ord_we) begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rec_rd_reg <= slot_mem[slot_raddr];
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
    end

    assign m_valid = m_valid_reg;

    // checks
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("request accepted while busy");

    a_nofree_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == lbc_pkg::STATUS_NOFREE
            |-> m_slot == 5'd0 && !m_hit && !m_need_read && m_ref_count == 8'd0)
        else $error("no free entry result not cleared");

    a_recycle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_need_read && !m_hit |-> m_ref_count == 8'd1)
        else $error("recycled entry count not one");

    a_hit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_ref_count != 8'd0)
        else $error("hit with zero count");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        a_vld_reg |-> a_pos_reg <= LAST)
        else $error("scan position out of range");

endmodule
